@@ rtl/core/rrsp_pkg.sv @@
// shared types and constants for the reply stream parser
// used by every module under rtl/core; no dependencies
package rrsp_pkg;

  localparam int LENGTH_BITS_DEF = 32;
  localparam int COUNT_BITS_DEF  = 16;
  localparam int QUEUE_DEPTH     = 4;
  localparam int QUEUE_PTR_BITS  = $clog2(QUEUE_DEPTH);

  localparam logic [7:0] CH_CR     = 8'd13;
  localparam logic [7:0] CH_LF     = 8'd10;
  localparam logic [7:0] CH_TAB    = 8'd9;
  localparam logic [7:0] CH_VT     = 8'd11;
  localparam logic [7:0] CH_FF     = 8'd12;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_STAR   = 8'h2a;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_PLUS   = 8'h2b;
  localparam logic [7:0] CH_MINUS  = 8'h2d;
  localparam logic [7:0] CH_COLON  = 8'h3a;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  localparam logic [2:0] K_STR = 3'd0;
  localparam logic [2:0] K_INT = 3'd1;
  localparam logic [2:0] K_NIL = 3'd2;
  localparam logic [2:0] K_ARR = 3'd3;
  localparam logic [2:0] K_ERR = 3'd4;

  typedef enum logic [2:0] {
    T_ARRAY,
    T_BULK,
    T_SIMPLE,
    T_INTEGER,
    T_BAD
  } type_code_t;

  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       last;
    logic       is_digit;
    logic       is_cr;
    logic       is_lf;
    logic       is_dollar;
    logic       is_minus;
    logic       is_plus;
    logic       is_blank;
    type_code_t tcode;
  } item_t;

  typedef struct packed {
    logic [7:0]  value;
    logic        pvalid;
    logic [15:0] elem;
    logic        eend;
    logic        done;
    logic [2:0]  kind;
  } result_t;

endpackage

@@ rtl/core/resp_reply_stream_parser.sv @@
// Reply stream parser: takes one reply byte per transfer and delivers one
// byte per cycle sustained while m_tready does not hold the output. A
// classifier front feeds a four-entry queue; the parser core updates its
// state for one byte per cycle and writes at most one result into an output
// register, so throughput is set by that state update.
// Headers saturate at 2^LENGTH_BITS-1 (lengths) and 2^COUNT_BITS-1 (counts).
// depends on rrsp_pkg, rrsp_front, rrsp_queue, rrsp_back
module resp_reply_stream_parser import rrsp_pkg::*; #(
  parameter int LENGTH_BITS = LENGTH_BITS_DEF,
  parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // data_byte
  input  logic        s_tuser,   // first_byte
  input  logic        s_tlast,   // last_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // payload_value, element_number
  output logic [4:0]  m_tuser,   // payload_valid, element_end, reply_kind
  output logic        m_tlast    // reply_done
);

  logic    q_full;
  logic    q_push;
  item_t   q_in;
  logic    q_pop;
  logic    q_valid;
  item_t   q_head;
  result_t res;

  rrsp_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (q_in)
  );

  rrsp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  rrsp_back #(
    .LENGTH_BITS (LENGTH_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_item  (q_head),
    .q_pop   (q_pop),
    .m_valid (m_tvalid),
    .m_ready (m_tready),
    .m_res   (res)
  );

  assign m_tdata = {res.elem, res.value};
  assign m_tuser = {res.kind, res.eend, res.pvalid};
  assign m_tlast = res.done;

endmodule

@@ rtl/core/rrsp_front.sv @@
// input side: accepts bytes and classifies them for the parser core
// depends on rrsp_pkg
module rrsp_front import rrsp_pkg::*; (
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,
  input  logic       s_tuser,
  input  logic       s_tlast,
  input  logic       q_full,
  output logic       q_push,
  output item_t      q_item
);

  logic [7:0] b;

  assign b        = s_tdata;
  assign s_tready = !q_full;
  assign q_push   = s_tvalid && !q_full;

  always_comb begin
    q_item.data      = b;
    q_item.first     = s_tuser;
    q_item.last      = s_tlast;
    q_item.is_digit  = (b >= CH_ZERO) && (b <= CH_NINE);
    q_item.is_cr     = (b == CH_CR);
    q_item.is_lf     = (b == CH_LF);
    q_item.is_dollar = (b == CH_DOLLAR);
    q_item.is_minus  = (b == CH_MINUS);
    q_item.is_plus   = (b == CH_PLUS);
    q_item.is_blank  = (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) ||
                       (b == CH_VT) || (b == CH_FF);
    case (b)
      CH_STAR:   q_item.tcode = T_ARRAY;
      CH_DOLLAR: q_item.tcode = T_BULK;
      CH_PLUS:   q_item.tcode = T_SIMPLE;
      CH_MINUS:  q_item.tcode = T_SIMPLE;
      CH_COLON:  q_item.tcode = T_INTEGER;
      default:   q_item.tcode = T_BAD;
    endcase
  end

endmodule

@@ rtl/core/rrsp_queue.sv @@
// short queue of classified bytes between the front and the parser core
// depends on rrsp_pkg
module rrsp_queue import rrsp_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  valid,
  output item_t head
);

  item_t                     mem [QUEUE_DEPTH];
  logic [QUEUE_PTR_BITS-1:0] wr_ptr;
  logic [QUEUE_PTR_BITS-1:0] rd_ptr;
  logic [QUEUE_PTR_BITS:0]   count;
  logic                      do_push;
  logic                      do_pop;

  assign full    = (count == (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH));
  assign valid   = (count != '0);
  assign head    = mem[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ rtl/core/rrsp_back.sv @@
// parser core: reply state machine, header number decode and result register
// depends on rrsp_pkg; fed by rrsp_queue
module rrsp_back import rrsp_pkg::*; #(
  parameter int LENGTH_BITS = LENGTH_BITS_DEF,
  parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    q_valid,
  input  item_t   q_item,
  output logic    q_pop,
  output logic    m_valid,
  input  logic    m_ready,
  output result_t m_res
);

  typedef enum logic [3:0] {
    P_IDLE,
    P_LINE,
    P_HDR0,
    P_HDR1,
    P_HDR2,
    P_PAYLOAD,
    P_TRAIL,
    P_ELEM
  } phase_t;

  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  phase_t                  phase, phase_next;
  logic                    hdr_cnt, hdr_cnt_next;
  logic [2:0]              kind, kind_next;
  logic [LENGTH_BITS-1:0]  acc, acc_next;
  logic                    neg, neg_next;
  logic [LENGTH_BITS-1:0]  bytes_left, bytes_left_next;
  logic [COUNT_BITS-1:0]   total, total_next;
  logic [COUNT_BITS-1:0]   seen, seen_next;
  logic                    held_cr, held_cr_next;
  logic [7:0]              held_byte, held_byte_next;
  logic                    held_valid, held_valid_next;
  logic                    take;
  logic                    res_valid;
  result_t                 res;
  logic [LENGTH_BITS+3:0]  acc_x10;
  logic [LENGTH_BITS-1:0]  acc_digit;

  assign take  = q_valid && (!m_valid || m_ready);
  assign q_pop = take;

  // decimal accumulate with saturation
  always_comb begin
    acc_x10 = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) +
              (LENGTH_BITS+4)'(q_item.data[3:0]);
    if (acc_x10[LENGTH_BITS+3 -: 4] != 4'b0) begin
      acc_digit = {LENGTH_BITS{1'b1}};
    end else begin
      acc_digit = acc_x10[LENGTH_BITS-1:0];
    end
  end

  always_comb begin
    logic                   ended;
    logic                   hdr_done;
    logic                   is_arr;
    logic [LENGTH_BITS-1:0] bl;
    logic [COUNT_BITS-1:0]  seen_inc;
    logic [15:0]            idx;

    phase_next      = phase;
    hdr_cnt_next    = hdr_cnt;
    kind_next       = kind;
    acc_next        = acc;
    neg_next        = neg;
    bytes_left_next = bytes_left;
    total_next      = total;
    seen_next       = seen;
    held_cr_next    = held_cr;
    held_byte_next  = held_byte;
    held_valid_next = held_valid;
    res_valid       = 1'b0;
    res             = '0;
    ended           = 1'b0;
    hdr_done        = 1'b0;
    is_arr          = (kind == K_ARR);
    bl              = bytes_left - 1'b1;
    seen_inc        = seen + 1'b1;
    idx             = is_arr ? 16'(seen) : 16'd0;

    if (take) begin
      if (q_item.first) begin
        phase_next      = P_IDLE;
        hdr_cnt_next    = 1'b0;
        kind_next       = K_STR;
        acc_next        = '0;
        neg_next        = 1'b0;
        bytes_left_next = '0;
        total_next      = '0;
        seen_next       = '0;
        held_cr_next    = 1'b0;
        held_byte_next  = '0;
        held_valid_next = 1'b0;
        case (q_item.tcode)
          T_ARRAY: begin
            phase_next   = P_HDR0;
            hdr_cnt_next = 1'b1;
            kind_next    = K_ARR;
          end
          T_BULK: begin
            phase_next = P_HDR0;
          end
          T_SIMPLE: begin
            phase_next = P_LINE;
          end
          T_INTEGER: begin
            phase_next = P_LINE;
            kind_next  = K_INT;
          end
          default: begin
            res_valid  = 1'b1;
            res.done   = 1'b1;
            res.kind   = K_ERR;
            ended      = 1'b1;
          end
        endcase
      end else begin
        case (phase)
          P_LINE: begin
            if (held_valid && held_cr && q_item.is_lf) begin
              held_valid_next = 1'b0;
              held_cr_next    = 1'b0;
              res_valid       = 1'b1;
              res.eend        = 1'b1;
              res.done        = 1'b1;
              res.kind        = kind;
              phase_next      = P_IDLE;
              ended           = 1'b1;
            end else begin
              if (held_valid) begin
                res_valid  = 1'b1;
                res.value  = held_byte;
                res.pvalid = 1'b1;
              end
              held_byte_next  = q_item.data;
              held_valid_next = 1'b1;
              held_cr_next    = q_item.is_cr;
            end
          end
          P_HDR0, P_HDR1, P_HDR2: begin
            if (held_cr && q_item.is_lf) begin
              held_cr_next = 1'b0;
              hdr_done     = 1'b1;
            end else begin
              held_cr_next = 1'b0;
              if (q_item.is_cr) begin
                held_cr_next = 1'b1;
                if (phase == P_HDR1) begin
                  phase_next = P_HDR2;
                end
              end else if (phase == P_HDR0) begin
                if (q_item.is_digit) begin
                  acc_next   = acc_digit;
                  phase_next = P_HDR1;
                end else if (q_item.is_minus) begin
                  neg_next   = 1'b1;
                  phase_next = P_HDR1;
                end else if (q_item.is_plus) begin
                  phase_next = P_HDR1;
                end else if (!q_item.is_blank) begin
                  phase_next = P_HDR2;
                end
              end else if (phase == P_HDR1) begin
                if (q_item.is_digit) begin
                  acc_next = acc_digit;
                end else begin
                  phase_next = P_HDR2;
                end
              end
            end
            if (hdr_done) begin
              if (hdr_cnt) begin
                if (neg && acc != '0) begin
                  res_valid = 1'b1;
                  res.done  = 1'b1;
                  res.kind  = K_ERR;
                  ended     = 1'b1;
                end else if (acc == '0) begin
                  res_valid = 1'b1;
                  res.done  = 1'b1;
                  res.kind  = K_NIL;
                  ended     = 1'b1;
                end else begin
                  if ((acc >> COUNT_BITS) != '0) begin
                    total_next = CNT_MAX;
                  end else begin
                    total_next = COUNT_BITS'(acc);
                  end
                  seen_next  = '0;
                  phase_next = P_ELEM;
                end
              end else if (is_arr && (neg || acc == '0)) begin
                res_valid = 1'b1;
                res.done  = 1'b1;
                res.kind  = K_ERR;
                ended     = 1'b1;
              end else if (!is_arr && (acc == '0 || (neg && acc == LENGTH_BITS'(1)))) begin
                res_valid = 1'b1;
                res.done  = 1'b1;
                res.kind  = K_NIL;
                ended     = 1'b1;
              end else if (neg) begin
                res_valid = 1'b1;
                res.done  = 1'b1;
                res.kind  = K_ERR;
                ended     = 1'b1;
              end else begin
                bytes_left_next = acc;
                phase_next      = P_PAYLOAD;
              end
            end
          end
          P_PAYLOAD: begin
            bytes_left_next = bl;
            res_valid       = 1'b1;
            res.value       = q_item.data;
            res.pvalid      = 1'b1;
            res.elem        = idx;
            if (bl == '0) begin
              res.eend = 1'b1;
              if (!is_arr) begin
                res.done = 1'b1;
                res.kind = K_STR;
                ended    = 1'b1;
              end else begin
                seen_next = seen_inc;
                if (seen_inc >= total) begin
                  res.done = 1'b1;
                  res.kind = K_ARR;
                  ended    = 1'b1;
                end else begin
                  bytes_left_next = LENGTH_BITS'(2);
                  phase_next      = P_TRAIL;
                end
              end
            end
          end
          P_TRAIL: begin
            bytes_left_next = bl;
            if (bl == '0) begin
              phase_next = P_ELEM;
            end
          end
          P_ELEM: begin
            if (!q_item.is_dollar) begin
              res_valid = 1'b1;
              res.done  = 1'b1;
              res.kind  = K_ERR;
              ended     = 1'b1;
            end else begin
              acc_next     = '0;
              neg_next     = 1'b0;
              held_cr_next = 1'b0;
              hdr_cnt_next = 1'b0;
              phase_next   = P_HDR0;
            end
          end
          default: begin
          end
        endcase
      end
      if (ended) begin
        phase_next = P_IDLE;
      end else if (q_item.last && phase_next != P_IDLE) begin
        // buffer ran out before the reply closed
        res_valid  = 1'b1;
        res        = '0;
        res.done   = 1'b1;
        res.kind   = K_ERR;
        phase_next = P_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= P_IDLE;
      hdr_cnt    <= 1'b0;
      kind       <= K_STR;
      acc        <= '0;
      neg        <= 1'b0;
      bytes_left <= '0;
      total      <= '0;
      seen       <= '0;
      held_cr    <= 1'b0;
      held_byte  <= '0;
      held_valid <= 1'b0;
      m_valid    <= 1'b0;
      m_res      <= '0;
    end else begin
      phase      <= phase_next;
      hdr_cnt    <= hdr_cnt_next;
      kind       <= kind_next;
      acc        <= acc_next;
      neg        <= neg_next;
      bytes_left <= bytes_left_next;
      total      <= total_next;
      seen       <= seen_next;
      held_cr    <= held_cr_next;
      held_byte  <= held_byte_next;
      held_valid <= held_valid_next;
      if (take && res_valid) begin
        m_valid <= 1'b1;
        m_res   <= res;
      end else if (m_ready) begin
        m_valid <= 1'b0;
      end
    end
  end

  a_done_goes_idle: assert property (@(posedge clk) disable iff (rst)
    take && res_valid && res.done |=> phase == P_IDLE)
    else $error("reply finished but parser not idle");

  a_payload_phase: assert property (@(posedge clk) disable iff (rst)
    take && res_valid && res.pvalid |-> (phase == P_LINE || phase == P_PAYLOAD))
    else $error("content byte outside a content phase");

  a_elem_in_range: assert property (@(posedge clk) disable iff (rst)
    phase == P_PAYLOAD && kind == K_ARR |-> seen < total)
    else $error("element index past array count");

  a_kind_only_done: assert property (@(posedge clk) disable iff (rst)
    take && res_valid && !res.done |-> res.kind == K_STR)
    else $error("reply kind set without completion");

  a_pop_needs_room: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid && (!m_valid || m_ready))
    else $error("queue popped without space in result register");

endmodule
